@@ design/psev_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Operation codes, status codes, command and state types shared by the blocks.
// ----------------------------------------------------------------------------
package psev_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;
   localparam logic [1:0] STATUS_DIV_ZERO  = 2'd3;

   localparam logic [31:0] NUMBER_MAX = 32'h7FFF_FFFF;

   typedef enum logic [4:0] {
      OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW,
      OP_GT, OP_GE, OP_LT, OP_LE, OP_EQ, OP_NE,
      OP_NOT, OP_AND, OP_OR, OP_NAND, OP_NOR, OP_XOR, OP_XNOR
   } op_type;

   typedef struct packed {
      logic        push_en;
      logic [31:0] value;
      op_type      op;
      logic        fin;
   } cmd_type;

   typedef enum logic [3:0] {
      BK_FETCH, BK_OP, BK_RDA, BK_RDB, BK_EXEC, BK_WB, BK_FIN, BK_RDT
   } back_state_type;

endpackage

@@ design/psev_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psev_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/psev_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator front end
// Accepts characters, builds numbers from digit runs and classifies operators.
// ----------------------------------------------------------------------------
module psev_front
   import psev_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] char_in,
   input  logic       last,
   input  logic       q_full,
   output logic       q_wr,
   output cmd_type    q_data
);

   logic [31:0] acc_ff, acc_in;
   logic        innum_ff, innum_in;
   logic        accept, digit;
   logic [35:0] sum;
   logic [31:0] next_acc;
   op_type      op;

   always_comb begin
      case (char_in)
         "+":     op = OP_ADD;
         "-":     op = OP_SUB;
         "*":     op = OP_MUL;
         "/":     op = OP_DIV;
         "%":     op = OP_MOD;
         "^":     op = OP_POW;
         "H":     op = OP_GT;
         "I":     op = OP_GE;
         "J":     op = OP_LT;
         "K":     op = OP_LE;
         "L":     op = OP_EQ;
         "M":     op = OP_NE;
         "A":     op = OP_NOT;
         "B":     op = OP_AND;
         "C":     op = OP_OR;
         "D":     op = OP_NAND;
         "E":     op = OP_NOR;
         "F":     op = OP_XOR;
         "G":     op = OP_XNOR;
         default: op = OP_NONE;
      endcase
   end

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign digit    = (char_in >= "0") && (char_in <= "9");
   assign sum      = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {32'd0, char_in[3:0]};
   assign next_acc = (sum > {4'd0, NUMBER_MAX}) ? NUMBER_MAX : sum[31:0];

   always_comb begin
      acc_in   = acc_ff;
      innum_in = innum_ff;
      q_wr     = 1'b0;
      q_data   = '{push_en: innum_ff, value: acc_ff, op: op, fin: last};
      if (digit) begin
         q_data = '{push_en: last, value: next_acc, op: OP_NONE, fin: last};
      end
      if (accept) begin
         q_wr = !digit || last;
         if (digit && !last) begin
            acc_in   = next_acc;
            innum_in = 1'b1;
         end else begin
            acc_in   = '0;
            innum_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         innum_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         innum_ff <= innum_in;
      end
   end

endmodule

@@ design/psev_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front end and the stack engine.
// ----------------------------------------------------------------------------
module psev_queue
   import psev_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr,
   input  cmd_type wdata,
   input  logic    rd,
   output cmd_type rdata,
   output logic    full,
   output logic    empty
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, rp_ff;
   logic [QUEUE_AW:0]   cnt_ff;

   assign full  = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (rd) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (wr && !rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (rd && !wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

@@ design/psev_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator stack engine
// Executes queued commands on the operand stack and delivers the result.
// ----------------------------------------------------------------------------
module psev_back
   import psev_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  cmd_type                          q_data,
   output logic                             q_rd,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [31:0]                      out_result,
   output logic [1:0]                       out_status,
   output logic [$clog2(STACK_DEPTH+1)-1:0] level
);

   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int AW  = $clog2(STACK_DEPTH);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [1:0]     err_ff, err_in;
   logic [31:0]    a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [31:0]    q_ff, q_in, d_ff, d_in;
   logic [32:0]    rem_ff, rem_in;
   logic [31:0]    pr_ff, pr_in, pb_ff, pb_in, pe_ff, pe_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           ov_ff, ov_in;
   logic [31:0]    or_ff, or_in;
   logic [1:0]     os_ff, os_in;

   logic           we, re;
   logic [AW-1:0]  waddr, raddr;
   logic [31:0]    wdata, rdata;
   logic [SPW-1:0] sp_m1, sp_m2;
   logic [32:0]    rem_sh;
   logic           ta, tb, out_free;
   logic [31:0]    prod_ab, prod_rb, prod_bb;

   psev_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .re(re), .raddr(raddr), .rdata(rdata)
   );

   assign sp_m1    = sp_ff - 1'b1;
   assign sp_m2    = sp_ff - 2'd2;
   assign ta       = (a_ff != '0);
   assign tb       = (b_ff != '0);
   assign rem_sh   = {rem_ff[31:0], q_ff[31]};
   assign prod_ab  = b_ff * a_ff;
   assign prod_rb  = pr_ff * pb_ff;
   assign prod_bb  = pb_ff * pb_ff;
   assign out_free = !ov_ff || out_ready;

   assign out_valid  = ov_ff;
   assign out_result = or_ff;
   assign out_status = os_ff;
   assign level      = sp_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      sp_in    = sp_ff;
      err_in   = err_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      q_in     = q_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      pr_in    = pr_ff;
      pb_in    = pb_ff;
      pe_in    = pe_ff;
      cnt_in   = cnt_ff;
      ov_in    = ov_ff && !out_ready;
      or_in    = or_ff;
      os_in    = os_ff;
      q_rd     = 1'b0;
      we       = 1'b0;
      waddr    = sp_ff[AW-1:0];
      wdata    = cmd_ff.value;
      re       = 1'b0;
      raddr    = sp_m1[AW-1:0];

      case (state_ff)
         BK_FETCH: begin
            if (!q_empty) begin
               q_rd     = 1'b1;
               cmd_in   = q_data;
               state_in = BK_OP;
               if (q_data.push_en) begin
                  if (sp_ff >= SPW'(STACK_DEPTH)) begin
                     if (err_ff == STATUS_OK) err_in = STATUS_OVERFLOW;
                  end else begin
                     we    = 1'b1;
                     wdata = q_data.value;
                     sp_in = sp_ff + 1'b1;
                  end
               end
            end
         end
         BK_OP: begin
            case (cmd_ff.op)
               OP_NONE: state_in = BK_FIN;
               OP_NOT: begin
                  if (sp_ff == '0) begin
                     if (err_ff == STATUS_OK) err_in = STATUS_UNDERFLOW;
                     state_in = BK_FIN;
                  end else begin
                     re       = 1'b1;
                     state_in = BK_RDA;
                  end
               end
               default: begin
                  if (sp_ff < SPW'(2)) begin
                     if (err_ff == STATUS_OK) err_in = STATUS_UNDERFLOW;
                     state_in = BK_FIN;
                  end else begin
                     re       = 1'b1;
                     state_in = BK_RDA;
                  end
               end
            endcase
         end
         BK_RDA: begin
            a_in = rdata;
            if (cmd_ff.op == OP_NOT) begin
               we       = 1'b1;
               waddr    = sp_m1[AW-1:0];
               wdata    = {31'd0, rdata == '0};
               state_in = BK_FIN;
            end else begin
               re       = 1'b1;
               raddr    = sp_m2[AW-1:0];
               state_in = BK_RDB;
            end
         end
         BK_RDB: begin
            b_in     = rdata;
            q_in     = rdata[31] ? (32'd0 - rdata) : rdata;
            d_in     = a_ff[31] ? (32'd0 - a_ff) : a_ff;
            rem_in   = '0;
            pr_in    = 32'd1;
            pb_in    = rdata;
            pe_in    = a_ff;
            cnt_in   = '0;
            state_in = BK_EXEC;
         end
         BK_EXEC: begin
            state_in = BK_WB;
            case (cmd_ff.op)
               OP_ADD:  res_in = b_ff + a_ff;
               OP_SUB:  res_in = b_ff - a_ff;
               OP_MUL:  res_in = prod_ab[31:0];
               OP_GT:   res_in = {31'd0, $signed(b_ff) >  $signed(a_ff)};
               OP_GE:   res_in = {31'd0, $signed(b_ff) >= $signed(a_ff)};
               OP_LT:   res_in = {31'd0, $signed(b_ff) <  $signed(a_ff)};
               OP_LE:   res_in = {31'd0, $signed(b_ff) <= $signed(a_ff)};
               OP_EQ:   res_in = {31'd0, b_ff == a_ff};
               OP_NE:   res_in = {31'd0, b_ff != a_ff};
               OP_AND:  res_in = {31'd0, ta && tb};
               OP_OR:   res_in = {31'd0, ta || tb};
               OP_NAND: res_in = {31'd0, !(ta && tb)};
               OP_NOR:  res_in = {31'd0, !(ta || tb)};
               OP_XOR:  res_in = {31'd0, ta != tb};
               OP_XNOR: res_in = {31'd0, ta == tb};
               OP_DIV, OP_MOD: begin
                  if (a_ff == '0) begin
                     res_in = '0;
                     if (err_ff == STATUS_OK) err_in = STATUS_DIV_ZERO;
                  end else if (cnt_ff == 6'd32) begin
                     // Quotient takes the sign of both operands, remainder that of b.
                     if (cmd_ff.op == OP_DIV) begin
                        res_in = (a_ff[31] ^ b_ff[31]) ? (32'd0 - q_ff) : q_ff;
                     end else begin
                        res_in = b_ff[31] ? (32'd0 - rem_ff[31:0]) : rem_ff[31:0];
                     end
                  end else begin
                     state_in = BK_EXEC;
                     cnt_in   = cnt_ff + 1'b1;
                     if (rem_sh >= {1'b0, d_ff}) begin
                        rem_in = rem_sh - {1'b0, d_ff};
                        q_in   = {q_ff[30:0], 1'b1};
                     end else begin
                        rem_in = rem_sh;
                        q_in   = {q_ff[30:0], 1'b0};
                     end
                  end
               end
               OP_POW: begin
                  if (a_ff[31]) begin
                     // Negative exponent: only a base of one or minus one survives.
                     if (b_ff == 32'd1) begin
                        res_in = 32'd1;
                     end else if (b_ff == 32'hFFFF_FFFF) begin
                        res_in = a_ff[0] ? 32'hFFFF_FFFF : 32'd1;
                     end else begin
                        res_in = '0;
                     end
                  end else if (cnt_ff == 6'd31) begin
                     res_in = pr_ff;
                  end else begin
                     state_in = BK_EXEC;
                     cnt_in   = cnt_ff + 1'b1;
                     if (pe_ff[0]) pr_in = prod_rb[31:0];
                     pb_in = prod_bb[31:0];
                     pe_in = {1'b0, pe_ff[31:1]};
                  end
               end
               default: res_in = '0;
            endcase
         end
         BK_WB: begin
            we       = 1'b1;
            waddr    = sp_m2[AW-1:0];
            wdata    = res_ff;
            sp_in    = sp_m1;
            state_in = BK_FIN;
         end
         BK_FIN: begin
            if (!cmd_ff.fin) begin
               state_in = BK_FETCH;
            end else if (sp_ff == '0) begin
               if (out_free) begin
                  ov_in    = 1'b1;
                  or_in    = '0;
                  os_in    = (err_ff == STATUS_OK) ? STATUS_UNDERFLOW : err_ff;
                  err_in   = STATUS_OK;
                  state_in = BK_FETCH;
               end
            end else begin
               re       = 1'b1;
               state_in = BK_RDT;
            end
         end
         BK_RDT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               or_in    = rdata;
               os_in    = err_ff;
               err_in   = STATUS_OK;
               sp_in    = '0;
               state_in = BK_FETCH;
            end
         end
         default: state_in = BK_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FETCH;
         sp_ff    <= '0;
         err_ff   <= STATUS_OK;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         err_ff   <= err_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      pr_ff  <= pr_in;
      pb_ff  <= pb_in;
      pe_ff  <= pe_in;
      cnt_ff <= cnt_in;
      or_ff  <= or_in;
      os_ff  <= os_in;
   end

endmodule

@@ design/postfix_stack_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates a postfix expression streamed one character per beat.
// ----------------------------------------------------------------------------
// A digit beat that is not the final beat is absorbed by the front end; other
// characters are queued for the stack engine. In the engine an ignored character
// passes through fetch, decode and finish, and NOT adds a stack read and write;
// addition, subtraction, multiply, comparisons and logic read both operands,
// execute and write back, while divide and modulo loop in the one-bit-a-step
// divider and power in the square-and-multiply loop (a zero divisor or a
// negative exponent skips the loop). The final beat adds a read of the top of
// the stack, none when the stack is empty, and the result may wait for the sink.
// A four-entry command queue lets characters keep arriving while the engine
// works. The stack lives in a RAM of STACK_DEPTH words.
module postfix_stack_evaluator
   import psev_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] result, [33:32] status, rest zero
);

   logic                             q_wr, q_rd, q_full, q_empty;
   cmd_type                          q_wdata, q_rdata;
   logic [31:0]                      result;
   logic [1:0]                       status;
   logic [$clog2(STACK_DEPTH+1)-1:0] level;

   psev_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .char_in(req_tdata), .last(req_tlast),
      .q_full(q_full), .q_wr(q_wr), .q_data(q_wdata)
   );

   psev_queue u_queue (
      .clock(clock), .reset(reset),
      .wr(q_wr), .wdata(q_wdata), .rd(q_rd), .rdata(q_rdata),
      .full(q_full), .empty(q_empty)
   );

   psev_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_data(q_rdata), .q_rd(q_rd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_result(result), .out_status(status), .level(level)
   );

   assign rsp_tdata = {6'd0, status, result};

`ifndef SYNTHESIS
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      q_wr |-> !q_full) else $error("command written into a full queue");
   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      q_rd |-> !q_empty) else $error("command read from an empty queue");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH)) else $error("stack level too high");
   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> level == '0) else $error("stack not emptied after result");
`endif

endmodule
